/* design/sc2a_pkg.sv */
// Shared types, scan codes and keyboard lookup tables for the scan code decoder.
`default_nettype none

package sc2a_pkg;

    // Scan code set 1 codes with a fixed meaning.
    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
    localparam logic [7:0] SC_CAPS_MAKE    = 8'h3A;

    // Codes of the action flag.
    localparam logic ACT_SCAN = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    localparam int CHAR_W = 7;

    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 7'h7A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET  = 7'd32;

    // What one scan code does to the keyboard state and the character queue.
    typedef struct packed {
        logic              shift_set;
        logic              shift_clr;
        logic              caps_toggle;
        logic              push;
        logic [CHAR_W-1:0] ch;
    } sc2a_key_t;

    function automatic logic is_lower(input logic [CHAR_W-1:0] ch);
        is_lower = (ch >= CHAR_LOWER_A) && (ch <= CHAR_LOWER_Z);
    endfunction

    // US layout without shift.
    function automatic logic [CHAR_W-1:0] plain_lookup(input logic [6:0] code);
        logic [CHAR_W-1:0] ch;
        case (code)
            7'h02: ch = 7'h31;
            7'h03: ch = 7'h32;
            7'h04: ch = 7'h33;
            7'h05: ch = 7'h34;
            7'h06: ch = 7'h35;
            7'h07: ch = 7'h36;
            7'h08: ch = 7'h37;
            7'h09: ch = 7'h38;
            7'h0A: ch = 7'h39;
            7'h0B: ch = 7'h30;
            7'h0C: ch = 7'h2D;
            7'h0D: ch = 7'h3D;
            7'h0E: ch = 7'h08;
            7'h0F: ch = 7'h09;
            7'h10: ch = 7'h71;
            7'h11: ch = 7'h77;
            7'h12: ch = 7'h65;
            7'h13: ch = 7'h72;
            7'h14: ch = 7'h74;
            7'h15: ch = 7'h79;
            7'h16: ch = 7'h75;
            7'h17: ch = 7'h69;
            7'h18: ch = 7'h6F;
            7'h19: ch = 7'h70;
            7'h1A: ch = 7'h5B;
            7'h1B: ch = 7'h5D;
            7'h1C: ch = 7'h0A;
            7'h1E: ch = 7'h61;
            7'h1F: ch = 7'h73;
            7'h20: ch = 7'h64;
            7'h21: ch = 7'h66;
            7'h22: ch = 7'h67;
            7'h23: ch = 7'h68;
            7'h24: ch = 7'h6A;
            7'h25: ch = 7'h6B;
            7'h26: ch = 7'h6C;
            7'h27: ch = 7'h3B;
            7'h28: ch = 7'h27;
            7'h29: ch = 7'h60;
            7'h2B: ch = 7'h5C;
            7'h2C: ch = 7'h7A;
            7'h2D: ch = 7'h78;
            7'h2E: ch = 7'h63;
            7'h2F: ch = 7'h76;
            7'h30: ch = 7'h62;
            7'h31: ch = 7'h6E;
            7'h32: ch = 7'h6D;
            7'h33: ch = 7'h2C;
            7'h34: ch = 7'h2E;
            7'h35: ch = 7'h2F;
            7'h37: ch = 7'h2A;
            7'h39: ch = 7'h20;
            7'h4C: ch = 7'h2D;
            7'h50: ch = 7'h2B;
            default: ch = '0;
        endcase
        plain_lookup = ch;
    endfunction

    // US layout with shift held. Letters are the plain letters in upper case.
    function automatic logic [CHAR_W-1:0] shifted_lookup(input logic [6:0] code);
        logic [CHAR_W-1:0] plain;
        logic [CHAR_W-1:0] ch;
        plain = plain_lookup(code);
        case (code)
            7'h02: ch = 7'h21;
            7'h03: ch = 7'h40;
            7'h04: ch = 7'h23;
            7'h05: ch = 7'h24;
            7'h06: ch = 7'h25;
            7'h07: ch = 7'h5E;
            7'h08: ch = 7'h26;
            7'h09: ch = 7'h2A;
            7'h0A: ch = 7'h28;
            7'h0B: ch = 7'h29;
            7'h0C: ch = 7'h5F;
            7'h0D: ch = 7'h2B;
            7'h1A: ch = 7'h7B;
            7'h1B: ch = 7'h7D;
            7'h27: ch = 7'h3A;
            7'h28: ch = 7'h22;
            7'h29: ch = 7'h7E;
            7'h2B: ch = 7'h7C;
            7'h33: ch = 7'h3C;
            7'h34: ch = 7'h3E;
            7'h35: ch = 7'h3F;
            default: ch = is_lower(plain) ? (plain - CASE_OFFSET) : plain;
        endcase
        shifted_lookup = ch;
    endfunction

endpackage

`default_nettype wire

/* design/sc2a_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module sc2a_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* design/sc2a_decode.sv */
// Scan code decoder: modifier tracking and table lookup for one scan code.
`default_nettype none

module sc2a_decode (
    input  wire logic [7:0]         scan_byte,
    input  wire logic               shift_active,
    input  wire logic               caps_active,
    output sc2a_pkg::sc2a_key_t     key
);

    import sc2a_pkg::*;

    logic               is_shift_make;
    logic               is_shift_break;
    logic               is_caps_make;
    logic [CHAR_W-1:0]  looked_up;
    logic [CHAR_W-1:0]  ch;

    // Modifier codes.
    assign is_shift_make  = (scan_byte == SC_LSHIFT_MAKE)  || (scan_byte == SC_RSHIFT_MAKE);
    assign is_shift_break = (scan_byte == SC_LSHIFT_BREAK) || (scan_byte == SC_RSHIFT_BREAK);
    assign is_caps_make   = (scan_byte == SC_CAPS_MAKE);

    // Table lookup, with caps lock raising letters only while shift is up.
    always_comb
    begin
        looked_up = shift_active ? shifted_lookup(scan_byte[6:0])
                                 : plain_lookup(scan_byte[6:0]);
        if (!shift_active && caps_active && is_lower(looked_up))
        begin
            ch = looked_up - CASE_OFFSET;
        end
        else
        begin
            ch = looked_up;
        end
    end

    // A break code other than shift is ignored; an unmapped make code pushes nothing.
    always_comb
    begin
        key.shift_set   = is_shift_make;
        key.shift_clr   = is_shift_break;
        key.caps_toggle = is_caps_make;
        key.push        = !is_shift_make && !is_caps_make && !scan_byte[7] && (ch != '0);
        key.ch          = ch;
    end

endmodule

`default_nettype wire

/* design/scancode_to_ascii_fifo.sv */
// Top level: scan code decoder feeding a character queue with pop requests.
// An input word is held in the input register, and its result then in the result register.
// Throughput: one input word per cycle while the result is taken; the decode, queue
// update and queue read each finish between the input and result registers.
// Reset clears the queue pointers, the shift and caps flags and both valid
// registers; the character store itself is not cleared and needs no sweep.
`default_nettype none

module scancode_to_ascii_fifo #(
    parameter int FIFO_DEPTH = 256
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] scan_byte
    input  wire logic       s_tuser,   // [0] action
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata    // [6:0] popped_char, [7] char_waiting
);

    import sc2a_pkg::*;

    localparam int               PTR_W    = $clog2(FIFO_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

    // Input register.
    logic             in_valid_reg;
    logic             in_action_reg;
    logic [7:0]       in_byte_reg;

    // Keyboard and queue state.
    logic             shift_reg;
    logic             shift_next;
    logic             caps_reg;
    logic             caps_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;

    // Result register.
    logic             out_valid_reg;
    logic             out_pop_reg;
    logic             out_wait_reg;

    logic              advance;
    logic              out_free;
    sc2a_key_t         key;
    logic [PTR_W-1:0]  wr_ptr_inc;
    logic [PTR_W-1:0]  rd_ptr_inc;
    logic              full;
    logic              empty;
    logic              do_push;
    logic              do_pop;
    logic [CHAR_W-1:0] rd_data;

    // Handshake: the result register frees when taken, the input register when it moves on.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_action_reg <= s_tuser;
            in_byte_reg   <= s_tdata;
        end
    end

    sc2a_decode u_decode (
        .scan_byte    (in_byte_reg),
        .shift_active (shift_reg),
        .caps_active  (caps_reg),
        .key          (key)
    );

    // Queue pointers wrap at the store depth; one slot stays free to tell full from empty.
    assign wr_ptr_inc = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
    assign full       = (wr_ptr_inc == rd_ptr_reg);
    assign empty      = (wr_ptr_reg == rd_ptr_reg);

    assign do_push = advance && (in_action_reg == ACT_SCAN) && key.push && !full;
    assign do_pop  = advance && (in_action_reg == ACT_POP) && !empty;

    // Next state of the flags and pointers.
    always_comb
    begin
        shift_next  = shift_reg;
        caps_next   = caps_reg;
        rd_ptr_next = do_pop  ? rd_ptr_inc : rd_ptr_reg;
        wr_ptr_next = do_push ? wr_ptr_inc : wr_ptr_reg;
        if (advance && (in_action_reg == ACT_SCAN))
        begin
            if (key.shift_set)
            begin
                shift_next = 1'b1;
            end
            else if (key.shift_clr)
            begin
                shift_next = 1'b0;
            end
            if (key.caps_toggle)
            begin
                caps_next = !caps_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg  <= 1'b0;
            caps_reg   <= 1'b0;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
        end
        else
        begin
            shift_reg  <= shift_next;
            caps_reg   <= caps_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
        end
    end

    // Character store; a pop reads the head entry into the RAM output register.
    sc2a_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (FIFO_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (do_push),
        .wr_addr (wr_ptr_reg),
        .wr_data (key.ch),
        .rd_en   (do_pop),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_data)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_pop_reg  <= do_pop;
            out_wait_reg <= (rd_ptr_next != wr_ptr_next);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_wait_reg, (out_pop_reg ? rd_data : {CHAR_W{1'b0}})};

endmodule

`default_nettype wire
